>>> rtl/uhe_pkg.sv
`timescale 1ns / 1ps
// uhe_pkg: shared types and constants for the histogram equalizer.
// No dependencies.
package uhe_pkg;
  localparam int LEVELS = 256;
  localparam int LVL_BITS = $clog2(LEVELS);
  localparam int COUNT_BITS = 24;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_COUNT = 2'd1,
    OP_BUILD = 2'd2,
    OP_MAP   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_CNT_RD, ST_CNT_WR, ST_BLD_RD, ST_BLD_WR,
    ST_MAP_RD, ST_MAP_DIV, ST_MAP_OUT
  } state_t;

  typedef struct packed {
    logic latch;      // load index from pixel or zero
    logic clr_wr;     // write zero to histogram at index
    logic idx_inc;    // advance index
    logic sum_clr;    // reset build sum
    logic hist_rd;    // read histogram at index
    logic cnt_wr;     // write incremented count
    logic bld_wr;     // write rank, accumulate sum
    logic rank_rd;    // read rank at pixel
    logic map_start;  // write back rank, start divider
    logic emit;       // drive result
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic div_done;
  } sts_t;
endpackage

>>> rtl/uhe_datapath.sv
`timescale 1ns / 1ps
// uhe_datapath: histogram and rank memories, build sum and rank-to-level divider.
// Depends on uhe_pkg.
module uhe_datapath import uhe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic [LVL_BITS-1:0]   pixel_value,
  input  logic [COUNT_BITS-1:0] pixels_per_channel,
  output logic [LVL_BITS-1:0]   equalized_value,
  output logic                  result_valid
);
  logic [COUNT_BITS-1:0] hist_mem [LEVELS];
  logic [COUNT_BITS-1:0] rank_mem [LEVELS];
  logic [LVL_BITS-1:0]   idx;
  logic [COUNT_BITS-1:0] hist_q;
  logic [COUNT_BITS-1:0] rank_q;
  logic [COUNT_BITS-1:0] sum;
  logic [COUNT_BITS:0]   sum_add;
  logic [COUNT_BITS-1:0] hist_inc;
  logic [COUNT_BITS-1:0] rank_inc;

  // divider: quotient of (rank - offset) by divisor, restoring, one bit a cycle
  logic [COUNT_BITS-1:0] div_rem;
  logic [COUNT_BITS-1:0] div_quo;
  logic [COUNT_BITS-1:0] div_den;
  logic [COUNT_BITS:0]   div_acc;
  logic [COUNT_BITS:0]   div_try;
  logic [4:0]            div_cnt;
  logic                  div_busy;
  logic [1:0]            div_kind;  // 0 top level, 1 in big span, 2 past big span
  logic [LVL_BITS-1:0]   rem_lv;
  logic [COUNT_BITS-1:0] base;
  logic [COUNT_BITS-1:0] big_span;
  logic [COUNT_BITS+LVL_BITS-1:0] big_span_w;
  logic [COUNT_BITS:0]   base_p1;
  logic [LVL_BITS:0]     lvl_sum;
  logic [LVL_BITS-1:0]   lvl_res;

  assign base    = pixels_per_channel >> LVL_BITS;
  assign rem_lv  = pixels_per_channel[LVL_BITS-1:0];
  assign base_p1 = {1'b0, base} + 1'b1;

  always_ff @(posedge clk) begin
    big_span_w <= rem_lv * base_p1[COUNT_BITS-1:0];
  end
  assign big_span = big_span_w[COUNT_BITS-1:0];

  assign sum_add  = {1'b0, sum} + {1'b0, hist_q};
  assign hist_inc = (hist_q == COUNT_MAX) ? COUNT_MAX : hist_q + 1'b1;
  assign rank_inc = (rank_q == COUNT_MAX) ? COUNT_MAX : rank_q + 1'b1;
  assign sts.idx_last = (idx == LVL_BITS'(LEVELS - 1));
  assign sts.div_done = !div_busy;

  always_ff @(posedge clk) begin
    if (rst) idx <= '0;
    else if (cmd.latch) idx <= (cmd.clr_wr || cmd.rank_rd) ? pixel_value : '0;
    else if (cmd.idx_inc) idx <= idx + 1'b1;
    if (cmd.hist_rd) hist_q <= hist_mem[idx];
    if (cmd.rank_rd) rank_q <= rank_mem[idx];
    if (cmd.cnt_wr) hist_mem[idx] <= hist_inc;
    else if (cmd.clr_wr && !cmd.latch) hist_mem[idx] <= '0;
    if (cmd.bld_wr) rank_mem[idx] <= sum;
    else if (cmd.map_start) rank_mem[idx] <= rank_inc;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.sum_clr) sum <= '0;
    else if (cmd.bld_wr) sum <= sum_add[COUNT_BITS] || sum_add[COUNT_BITS-1:0] == COUNT_MAX ?
                               COUNT_MAX : sum_add[COUNT_BITS-1:0];
  end

  assign div_acc = {div_rem[COUNT_BITS-1:0], div_quo[COUNT_BITS-1]};
  assign div_try = div_acc - {1'b0, div_den};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
    end else if (cmd.map_start) begin
      div_quo <= '0;
      div_rem <= '0;
      div_cnt <= 5'(COUNT_BITS);
      if (rank_q >= pixels_per_channel) begin
        div_kind <= 2'd0; div_busy <= 1'b0;
      end else if (rank_q < big_span) begin
        div_kind <= 2'd1; div_busy <= 1'b1;
        div_quo <= rank_q; div_den <= base_p1[COUNT_BITS-1:0];
      end else if (base == '0) begin
        div_kind <= 2'd0; div_busy <= 1'b0;
      end else begin
        div_kind <= 2'd2; div_busy <= 1'b1;
        div_quo <= rank_q - big_span; div_den <= base;
      end
    end else if (div_busy) begin
      if (!div_try[COUNT_BITS]) begin
        div_rem <= div_try[COUNT_BITS-1:0];
        div_quo <= {div_quo[COUNT_BITS-2:0], 1'b1};
      end else begin
        div_rem <= div_acc[COUNT_BITS-1:0];
        div_quo <= {div_quo[COUNT_BITS-2:0], 1'b0};
      end
      div_cnt <= div_cnt - 1'b1;
      if (div_cnt == 5'd1) div_busy <= 1'b0;
    end
  end

  // clamp quotient (plus offset) to the top level
  always_comb begin
    lvl_sum = '0;
    lvl_res = LVL_BITS'(LEVELS - 1);
    if (div_kind == 2'd1) begin
      if (div_quo[COUNT_BITS-1:LVL_BITS] == '0) lvl_res = div_quo[LVL_BITS-1:0];
    end else if (div_kind == 2'd2) begin
      lvl_sum = {1'b0, rem_lv} + {1'b0, div_quo[LVL_BITS-1:0]};
      if (div_quo[COUNT_BITS-1:LVL_BITS] == '0 && !lvl_sum[LVL_BITS])
        lvl_res = lvl_sum[LVL_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else result_valid <= cmd.emit;
    if (cmd.emit) equalized_value <= lvl_res;
  end
endmodule

>>> rtl/uhe_ctrl.sv
`timescale 1ns / 1ps
// uhe_ctrl: sequencer for clear, count, build and map items.
// Depends on uhe_pkg.
module uhe_ctrl import uhe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] opcode,
  output logic       busy,
  output cmd_t       cmd,
  input  sts_t       sts
);
  state_t state, state_next;
  op_t    op_in;

  assign op_in = op_t'(opcode);

  // come out of reset with a clearing pass over the histogram
  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          unique case (op_in)
            OP_CLEAR: state_next = ST_CLEAR;
            OP_COUNT: state_next = ST_CNT_RD;
            OP_BUILD: state_next = ST_BLD_RD;
            OP_MAP:   state_next = ST_MAP_RD;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR:   if (sts.idx_last) state_next = ST_IDLE;
      ST_CNT_RD:  state_next = ST_CNT_WR;
      ST_CNT_WR:  state_next = ST_IDLE;
      ST_BLD_RD:  state_next = ST_BLD_WR;
      ST_BLD_WR:  state_next = sts.idx_last ? ST_IDLE : ST_BLD_RD;
      ST_MAP_RD:  state_next = ST_MAP_DIV;
      ST_MAP_DIV: state_next = ST_MAP_OUT;
      ST_MAP_OUT: if (sts.div_done) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.latch   = 1'b1;
          cmd.sum_clr = 1'b1;
          // latch sets index: pixel for count/map, zero otherwise
          cmd.clr_wr  = (op_in == OP_COUNT);
          cmd.rank_rd = (op_in == OP_MAP);
        end
      end
      ST_CLEAR:   begin cmd.clr_wr = 1'b1; cmd.idx_inc = 1'b1; end
      ST_CNT_RD:  cmd.hist_rd = 1'b1;
      ST_CNT_WR:  cmd.cnt_wr = 1'b1;
      ST_BLD_RD:  cmd.hist_rd = 1'b1;
      ST_BLD_WR:  begin cmd.bld_wr = 1'b1; cmd.idx_inc = 1'b1; end
      ST_MAP_RD:  cmd.rank_rd = 1'b1;
      ST_MAP_DIV: cmd.map_start = 1'b1;
      ST_MAP_OUT: cmd.emit = sts.div_done;
      default:    cmd = '0;
    endcase
  end
endmodule

>>> rtl/uniform_histogram_equalizer.sv
`timescale 1ns / 1ps
// uniform_histogram_equalizer: top level, joins sequencer and datapath.
// Depends on uhe_pkg, uhe_ctrl, uhe_datapath.
//
//  channel | ports                              | handshake
//  --------+------------------------------------+---------------------------
//  item    | opcode, pixel_value                | start & !busy
//  result  | equalized_value                    | result_valid, one cycle
//  config  | pixels_per_channel_wr/_data        | write enable, no wait
//
// Count reads then writes one histogram entry; clear walks every level;
// build reads then writes per level; map waits on the rank-to-level
// divider unless the rank needs no division, and the divider resolves one
// quotient bit per cycle. Reset is synchronous; after it busy stays high
// for a pass that zeroes the histogram.
// The result strobe lasts one cycle; the receiver cannot stall it.
module uniform_histogram_equalizer import uhe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            opcode,
  input  logic [7:0]            pixel_value,
  input  logic                  pixels_per_channel_wr,
  input  logic [23:0]           pixels_per_channel_data,
  output logic                  result_valid,
  output logic [7:0]            equalized_value
);
  cmd_t cmd;
  sts_t sts;
  logic [COUNT_BITS-1:0] pixels_per_channel;
  logic                  rank_sel;
  logic [LVL_BITS-1:0]   px_q;

  always_ff @(posedge clk) begin
    if (rst) pixels_per_channel <= COUNT_BITS'(65536);
    else if (pixels_per_channel_wr) pixels_per_channel <= pixels_per_channel_data;
  end

  assign rank_sel = 1'b0;
  assign px_q = (start && !busy && opcode == OP_BUILD) ? '0 :
                (rank_sel ? '0 : pixel_value);

  uhe_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .opcode(opcode),
    .busy(busy), .cmd(cmd), .sts(sts)
  );

  uhe_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .pixel_value(px_q), .pixels_per_channel(pixels_per_channel),
    .equalized_value(equalized_value), .result_valid(result_valid)
  );
endmodule

>>> verif/uniform_histogram_equalizer_tb.sv
`timescale 1ns / 1ps
// uniform_histogram_equalizer_tb: self-checking bench for the histogram equalizer.
// It predicts every equalized level from its own histogram and rank tables.
// Depends on uhe_pkg and uniform_histogram_equalizer.
module uniform_histogram_equalizer_tb;
  import uhe_pkg::*;

  localparam int KIND_ITEM  = 0;
  localparam int KIND_CFG   = 1;
  localparam int KIND_DRAIN = 2;
  localparam int QUIET_CYCLES = 600;  // longer than a build pass

  typedef struct {
    int               kind;
    op_t              op;
    logic [7:0]       px;
    logic [23:0]      val;
  } beat_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  opcode;
  logic [7:0]  pixel_value;
  logic        cfg_wr;
  logic [23:0] cfg_data;
  logic        result_valid;
  logic [7:0]  equalized_value;

  uniform_histogram_equalizer dut (
    .clk                     (clk),
    .rst                     (rst),
    .start                   (start),
    .busy                    (busy),
    .opcode                  (opcode),
    .pixel_value             (pixel_value),
    .pixels_per_channel_wr   (cfg_wr),
    .pixels_per_channel_data (cfg_data),
    .result_valid            (result_valid),
    .equalized_value         (equalized_value)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Predictor state
  logic [23:0] hist_count [LEVELS];
  logic [23:0] rank_next [LEVELS];
  logic [23:0] pixel_total;
  logic [7:0]  level_queue [$];

  beat_t       pending [$];
  int          gap;
  int          quiet;
  bit          no_idle;
  bit          taken;
  int          errors;
  int          results_seen;
  int          items_sent;
  int          cfg_writes;
  int          gen_items;

  function automatic logic [23:0] sat_inc(logic [23:0] v);
    return (v == COUNT_MAX) ? COUNT_MAX : v + 24'd1;
  endfunction

  function automatic logic [7:0] rank_to_level(logic [23:0] rank);
    longint unsigned n, base, rem, span, r, q;
    n = pixel_total;
    base = n / LEVELS;
    rem = n % LEVELS;
    span = rem * (base + 1);
    r = rank;
    if (r >= n) return 8'(LEVELS - 1);
    if (r < span) q = r / (base + 1);
    else if (base == 0) return 8'(LEVELS - 1);
    else q = rem + (r - span) / base;
    return (q >= LEVELS) ? 8'(LEVELS - 1) : 8'(q);
  endfunction

  task automatic apply_item(op_t op, logic [7:0] px);
    logic [24:0] sum;
    case (op)
      OP_CLEAR: for (int i = 0; i < LEVELS; i++) hist_count[i] = '0;
      OP_COUNT: hist_count[px] = sat_inc(hist_count[px]);
      OP_BUILD: begin
        sum = '0;
        for (int i = 0; i < LEVELS; i++) begin
          rank_next[i] = sum[23:0];
          sum = sum + hist_count[i];
          if (sum >= COUNT_MAX) sum = COUNT_MAX;
        end
      end
      default: begin
        level_queue.push_back(rank_to_level(rank_next[px]));
        rank_next[px] = sat_inc(rank_next[px]);
      end
    endcase
  endtask

  // Acceptance and result checking
  always @(posedge clk) begin
    if (rst) begin
      pixel_total = 24'd65536;
      quiet = 0;
    end else begin
      quiet = quiet + 1;
      if (cfg_wr) pixel_total = cfg_data;
      if (result_valid) begin
        results_seen++;
        if (level_queue.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %0d", $realtime,
                   equalized_value);
        end else begin
          if (equalized_value !== level_queue[0]) begin
            errors++;
            $display("%0t: equalized_value mismatch, expected %0d, actual %0d",
                     $realtime, level_queue[0], equalized_value);
          end
          void'(level_queue.pop_front());
        end
      end
      if (start && !busy) begin
        apply_item(op_t'(opcode), pixel_value);
        items_sent++;
        quiet = 0;
        taken = 1'b1;
      end
    end
  end

  // Driver
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
      cfg_wr <= 1'b0;
      gap = 0;
      taken = 1'b0;
    end else if (!(start && !taken)) begin
      taken = 1'b0;
      cfg_wr <= 1'b0;
      if (gap > 0) begin
        start <= 1'b0;
        gap--;
      end else if (pending.size() == 0) begin
        start <= 1'b0;
      end else if (pending[0].kind == KIND_ITEM) begin
        start <= 1'b1;
        opcode <= pending[0].op;
        pixel_value <= pending[0].px;
        void'(pending.pop_front());
        gap = no_idle ? 0 : $urandom_range(0, 3);
      end else begin
        start <= 1'b0;
        if (level_queue.size() == 0 && !busy) begin
          if (pending[0].kind == KIND_DRAIN) begin
            void'(pending.pop_front());
          end else if (quiet >= QUIET_CYCLES) begin
            cfg_wr <= 1'b1;
            cfg_data <= pending[0].val;
            cfg_writes++;
            void'(pending.pop_front());
            no_idle = ($urandom_range(0, 3) == 0);
          end
        end
      end
    end
  end

  task automatic push_item(op_t op, logic [7:0] px);
    beat_t b;
    b.kind = KIND_ITEM;
    b.op = op;
    b.px = px;
    b.val = '0;
    pending.push_back(b);
    gen_items++;
  endtask

  task automatic push_ctrl(int kind, logic [23:0] val);
    beat_t b;
    b.kind = kind;
    b.op = OP_CLEAR;
    b.px = '0;
    b.val = val;
    pending.push_back(b);
  endtask

  // One equalization pass: set the pixel count, mostly clear, count a set of pixels, build ranks, map them back
  task automatic gen_pass(int npix, logic [23:0] n_cfg);
    logic [7:0] pix [$];
    logic [7:0] lo, hi, t;
    int j;
    push_ctrl(KIND_CFG, n_cfg);
    lo = 8'($urandom_range(0, 255));
    hi = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'($urandom_range(lo, 255));
    if ($urandom_range(0, 4) != 0) push_item(OP_CLEAR, '0);
    for (int i = 0; i < npix; i++) begin
      pix.push_back(8'($urandom_range(lo, hi)));
      push_item(OP_COUNT, pix[i]);
    end
    push_item(OP_BUILD, '0);
    for (int i = npix - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = pix[i];
      pix[i] = pix[j];
      pix[j] = t;
    end
    for (int i = 0; i < npix; i++) begin
      push_item(OP_MAP, pix[i]);
      // occasional stray beat between maps
      if ($urandom_range(0, 15) == 0) push_item(op_t'(2'($urandom_range(1, 3))),
                                                 8'($urandom_range(0, 255)));
    end
    for (int i = $urandom_range(0, 3); i > 0; i--)
      push_item(OP_MAP, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    logic [23:0] n_cfg;
    int npix;
    rst = 1'b1;
    start = 1'b0;
    opcode = '0;
    pixel_value = '0;
    cfg_wr = 1'b0;
    cfg_data = '0;
    errors = 0;
    results_seen = 0;
    items_sent = 0;
    cfg_writes = 0;
    gen_items = 0;
    no_idle = 1'b0;
    for (int i = 0; i < LEVELS; i++) begin
      hist_count[i] = '0;
      rank_next[i] = '0;
    end

    // Directed: extremes under the reset pixel count, then maps past the total
    push_item(OP_CLEAR, '0);
    push_item(OP_COUNT, 8'd0);
    push_item(OP_COUNT, 8'd255);
    push_item(OP_COUNT, 8'd255);
    push_item(OP_COUNT, 8'h55);
    push_item(OP_COUNT, 8'hAA);
    push_item(OP_BUILD, '0);
    push_item(OP_MAP, 8'd0);
    push_item(OP_MAP, 8'd255);
    push_item(OP_MAP, 8'd255);
    push_item(OP_MAP, 8'd255);
    push_item(OP_MAP, 8'h55);
    push_item(OP_MAP, 8'hAA);
    push_item(OP_MAP, 8'd0);
    push_ctrl(KIND_DRAIN, '0);
    push_ctrl(KIND_CFG, 24'd5);
    push_item(OP_BUILD, '0);
    for (int i = 0; i < 7; i++) push_item(OP_MAP, (i < 4) ? 8'd255 : 8'd0);

    // Random passes, first two at the pixel count extremes
    for (int p = 0; gen_items < 950; p++) begin
      npix = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120) : $urandom_range(3, 40);
      case (p == 0 ? 0 : p == 1 ? 1 : $urandom_range(2, 6))
        0: n_cfg = 24'd1;
        1: n_cfg = 24'hFFFFFF;
        2: n_cfg = 24'($urandom_range(1, 600));
        3: n_cfg = (npix > 2) ? 24'(npix / 2) : 24'd1;
        default: n_cfg = 24'(npix);
      endcase
      gen_pass(npix, n_cfg);
      if ((p % 5) == 3) push_ctrl(KIND_DRAIN, '0);
    end
    push_ctrl(KIND_CFG, 24'd65536);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    wait (pending.size() == 0 && !start && level_queue.size() == 0);
    repeat (QUIET_CYCLES) @(posedge clk);
    $display("Ran %0d items (clear, count, build, map) with %0d pixel count writes,",
             items_sent, cfg_writes);
    $display("checked %0d equalized levels, %0d mismatches.", results_seen, errors);
    if (errors == 0 && level_queue.size() == 0) begin
      $display("PASS uniform_histogram_equalizer");
    end else begin
      $display("FAIL uniform_histogram_equalizer");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL uniform_histogram_equalizer");
    $finish;
  end
endmodule
